@@ rtl/eect_pkg.sv @@
`default_nettype none

package eect_pkg;

    // item codes
    localparam logic [1:0] MODE_EVENT = 2'd0;
    localparam logic [1:0] MODE_CLEAR = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    // result codes
    localparam logic [2:0] ST_COUNTED   = 3'd0;
    localparam logic [2:0] ST_CREATED   = 3'd1;
    localparam logic [2:0] ST_IGNORED   = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_CLEARED   = 3'd4;
    localparam logic [2:0] ST_REFUSED   = 3'd5;
    localparam logic [2:0] ST_READ_OK   = 3'd6;
    localparam logic [2:0] ST_BAD_INDEX = 3'd7;

    // configuration register indexes
    localparam logic CFG_RUNNING    = 1'b0;
    localparam logic CFG_HOST_TRACE = 1'b1;

    // class given to entries made by offload events
    localparam logic [7:0] CLASS_AUDIO = 8'd1;

    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] key_slot;
        logic [7:0] key_endpoint;
        logic       direction_in;
        logic [7:0] class_code;
        logic       from_offload;
        logic [2:0] read_index;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  entries_in_use;
        logic [2:0]  entry_index;
        logic [7:0]  entry_slot;
        logic [7:0]  entry_endpoint;
        logic        entry_direction;
        logic [7:0]  entry_class;
        logic [31:0] entry_count;
    } out_item_t;

    // one table entry as it sits in memory
    typedef struct packed {
        logic [7:0]  slot;
        logic [7:0]  endpoint;
        logic        direction;
        logic [7:0]  cls;
        logic [31:0] count;
    } entry_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RDATA,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

@@ rtl/eect_ram.sv @@
`default_nettype none

module eect_ram #(
    parameter int DEPTH = 5,
    parameter int AW    = 3
) (
    input  wire                  clk,
    input  wire                  we,
    input  wire  [AW-1:0]        waddr,
    input  eect_pkg::entry_t     wdata,
    input  wire  [AW-1:0]        raddr,
    output eect_pkg::entry_t     rdata
);
    import eect_pkg::*;

    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read: data follows the address in the next cycle
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ rtl/endpoint_event_count_table_unit.sv @@
`default_nettype none

// channel   direction  handshake            payload
// in        input      in_valid / in_stall   in_item   (mode, key, direction, class, index)
// out       output     out_valid / out_stall out_item  (status, use count, entry fields)
// cfg       input      cfg_valid / cfg_ready cfg_index, cfg_data (running, host trace enable)
//
// one item at a time; an event reads the entries in use one per cycle from the memory
// and stops at the first hit or once every entry is read; a read takes its entry from
// the memory, clear and ignored items go straight to the result register, which passes
// to the output register once that is free; the next item is taken after that hand-off;
// reset clears control, the configuration registers and the use count only
// a stalled output holds its item, and the input stays stalled until the result moves on

module endpoint_event_count_table_unit #(
    parameter int TABLE_ENTRIES = 5
) (
    input  wire                   clk,
    input  wire                   rst_n,

    input  wire                   in_valid,
    output logic                  in_stall,
    input  eect_pkg::in_item_t    in_item,

    output logic                  out_valid,
    input  wire                   out_stall,
    output eect_pkg::out_item_t   out_item,

    input  wire                   cfg_valid,
    output logic                  cfg_ready,
    input  wire                   cfg_index,
    input  wire                   cfg_data
);
    import eect_pkg::*;

    // address width, use count width, and a width wide enough to compare both
    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int IW = (CW > 3) ? CW : 3;

    state_t           state_reg, state_next;
    in_item_t         item_reg, item_next;
    logic [CW-1:0]    used_reg, used_next;
    logic [CW-1:0]    scan_reg, scan_next;     // next entry to read
    logic             cmp_vld_reg, cmp_vld_next; // read data is a live compare
    logic [AW-1:0]    cmp_idx_reg, cmp_idx_next;
    out_item_t        res_reg, res_next;
    out_item_t        out_reg, out_next;
    logic             out_vld_reg, out_vld_next;
    logic             running_reg;
    logic             host_reg;

    // memory port signals
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    entry_t           mem_wdata;
    logic [AW-1:0]    mem_raddr;
    entry_t           mem_rdata;

    logic [IW-1:0]    ridx_w;
    logic [IW-1:0]    used_w;
    logic             accept;
    logic             hit;
    logic             out_free;

    eect_ram #(
        .DEPTH (TABLE_ENTRIES),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_vld_reg;
    assign out_item  = out_reg;
    assign cfg_ready = 1'b1;
    assign out_free  = !out_vld_reg || !out_stall;

    assign ridx_w = IW'(in_item.read_index);
    assign used_w = IW'(used_reg);

    // key match against the entry read last cycle
    assign hit = cmp_vld_reg
              && (mem_rdata.slot == item_reg.key_slot)
              && (mem_rdata.endpoint == item_reg.key_endpoint);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            host_reg    <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_RUNNING:    running_reg <= cfg_data;
                CFG_HOST_TRACE: host_reg    <= cfg_data;
                default:        ;
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            used_reg    <= '0;
            cmp_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            cmp_vld_reg <= cmp_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // payload and scan registers
    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        scan_reg    <= scan_next;
        cmp_idx_reg <= cmp_idx_next;
        res_reg     <= res_next;
        out_reg     <= out_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        item_next    = item_reg;
        used_next    = used_reg;
        scan_next    = scan_reg;
        cmp_vld_next = 1'b0;
        cmp_idx_next = cmp_idx_reg;
        res_next     = res_reg;
        out_next     = out_reg;
        out_vld_next = out_vld_reg && out_stall;

        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = mem_rdata;
        mem_raddr = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                // a read item gets its address issued right away
                mem_raddr = ridx_w[AW-1:0];
                if (accept)
                begin
                    item_next = in_item;
                    res_next  = '0;
                    priority if (in_item.mode == MODE_EVENT)
                    begin
                        if (running_reg && (in_item.from_offload || host_reg))
                        begin
                            scan_next  = '0;
                            state_next = S_SCAN;
                        end
                        else
                        begin
                            res_next.status         = ST_IGNORED;
                            res_next.entries_in_use = 3'(used_reg);
                            state_next              = S_DONE;
                        end
                    end
                    else if (in_item.mode == MODE_CLEAR)
                    begin
                        if (running_reg)
                        begin
                            res_next.status         = ST_REFUSED;
                            res_next.entries_in_use = 3'(used_reg);
                        end
                        else
                        begin
                            used_next               = '0;
                            res_next.status         = ST_CLEARED;
                            res_next.entries_in_use = 3'd0;
                        end
                        state_next = S_DONE;
                    end
                    else if (in_item.mode == MODE_READ)
                    begin
                        if (ridx_w < used_w)
                        begin
                            state_next = S_RDATA;
                        end
                        else
                        begin
                            res_next.status         = ST_BAD_INDEX;
                            res_next.entries_in_use = 3'(used_reg);
                            state_next              = S_DONE;
                        end
                    end
                    else
                    begin
                        // unused mode code
                        res_next.status         = ST_IGNORED;
                        res_next.entries_in_use = 3'(used_reg);
                        state_next              = S_DONE;
                    end
                end
            end

            S_RDATA:
            begin
                res_next                 = '0;
                res_next.status          = ST_READ_OK;
                res_next.entries_in_use  = 3'(used_reg);
                res_next.entry_index     = item_reg.read_index;
                res_next.entry_slot      = mem_rdata.slot;
                res_next.entry_endpoint  = mem_rdata.endpoint;
                res_next.entry_direction = mem_rdata.direction;
                res_next.entry_class     = mem_rdata.cls;
                res_next.entry_count     = mem_rdata.count;
                state_next               = S_DONE;
            end

            S_SCAN:
            begin
                // issue the next read while comparing the last one
                if (scan_reg < used_reg)
                begin
                    mem_raddr    = scan_reg[AW-1:0];
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = scan_reg[AW-1:0];
                    scan_next    = scan_reg + CW'(1);
                end

                if (hit)
                begin
                    // bump the count, saturating, and write the entry back
                    mem_we          = 1'b1;
                    mem_waddr       = cmp_idx_reg;
                    mem_wdata       = mem_rdata;
                    if (mem_rdata.count != COUNT_MAX)
                    begin
                        mem_wdata.count = mem_rdata.count + 32'd1;
                    end
                    cmp_vld_next             = 1'b0;
                    res_next                 = '0;
                    res_next.status          = ST_COUNTED;
                    res_next.entries_in_use  = 3'(used_reg);
                    res_next.entry_index     = 3'(cmp_idx_reg);
                    res_next.entry_slot      = mem_rdata.slot;
                    res_next.entry_endpoint  = mem_rdata.endpoint;
                    res_next.entry_direction = mem_rdata.direction;
                    res_next.entry_class     = mem_rdata.cls;
                    res_next.entry_count     = mem_wdata.count;
                    state_next               = S_DONE;
                end
                else if (!cmp_vld_reg && (scan_reg == used_reg))
                begin
                    // walked every entry without a match
                    res_next = '0;
                    if (used_reg == CW'(TABLE_ENTRIES))
                    begin
                        res_next.status         = ST_FULL;
                        res_next.entries_in_use = 3'(used_reg);
                    end
                    else
                    begin
                        mem_we              = 1'b1;
                        mem_waddr           = used_reg[AW-1:0];
                        mem_wdata.slot      = item_reg.key_slot;
                        mem_wdata.endpoint  = item_reg.key_endpoint;
                        mem_wdata.direction = item_reg.direction_in;
                        mem_wdata.cls       = item_reg.from_offload ? CLASS_AUDIO
                                                                    : item_reg.class_code;
                        mem_wdata.count     = 32'd1;
                        used_next           = used_reg + CW'(1);

                        res_next.status          = ST_CREATED;
                        res_next.entries_in_use  = 3'(used_next);
                        res_next.entry_index     = 3'(used_reg);
                        res_next.entry_slot      = mem_wdata.slot;
                        res_next.entry_endpoint  = mem_wdata.endpoint;
                        res_next.entry_direction = mem_wdata.direction;
                        res_next.entry_class     = mem_wdata.cls;
                        res_next.entry_count     = mem_wdata.count;
                    end
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                // hand the result to the output register once it is free
                if (out_free)
                begin
                    out_next     = res_reg;
                    out_vld_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ test/tb.sv @@
`timescale 1ns / 100ps

// self-checking bench for the endpoint event count table
// a short directed table walks reset state, extremes and every status code,
// then random phases hit a small pool of keys so entries match, fill and clear

module tb;
    import eect_pkg::*;

    localparam int TABLE_ENTRIES = 5;
    localparam logic [1:0] MODE_UNUSED = 2'd3;  // spare mode, block must ignore it
    localparam int KEY_POOL = 7;                // more keys than entries, so full drops happen
    localparam int PHASE_ITEMS = 30;
    localparam int ITEM_GOAL = 750;             // items sent over the whole run
    localparam int LONG_HOLD = 400;             // output hold-off, in cycles
    localparam int DRAIN_CYCLES = 20;
    localparam int TIMEOUT_NS = 2_000_000;

    // one line of stimulus: a register write or an item, with an optional
    // hand-typed result
    typedef struct {
        bit        is_reg;
        logic      reg_idx;
        logic      reg_val;
        in_item_t  item;
        bit        typed;
        out_item_t typed_res;
    } row_t;

    logic      clk;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    in_item_t  in_item = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_item_t out_item;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic      cfg_index = 1'b0;
    logic      cfg_data = 1'b0;

    // shadow of the table and its registers
    entry_t shadow_tbl [TABLE_ENTRIES];
    int     shadow_used = 0;
    logic   run_q = 1'b0;
    logic   trace_q = 1'b0;

    row_t      send_q [$];
    out_item_t expected_results [$];
    row_t      directed [$];

    logic [7:0] pool_slot [KEY_POOL];
    logic [7:0] pool_ep [KEY_POOL];

    int pushed_cnt = 0;
    int accepted_cnt = 0;
    int useful_cnt = 0;
    int checked_cnt = 0;
    int mismatches = 0;
    int status_tally [8];

    // idling control shared by both sides, and the receiver's long hold request
    int idle_pct = 30;
    bit quiet = 1'b0;
    bit long_hold_req = 1'b0;

    endpoint_event_count_table_unit #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_item(in_item),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_item(out_item),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // hard stop in case the block hangs
    initial
    begin
        #(TIMEOUT_NS);
        $display("timed out with %0d results outstanding", expected_results.size());
        $display("status: fail");
        $finish;
    end

    // works out the result of one item and updates the shadow table
    function automatic out_item_t predict_table_result(in_item_t it);
        out_item_t r;
        int hit;
        int i;
        r = '0;
        r.status = ST_IGNORED;
        hit = -1;
        case (it.mode)
            MODE_EVENT:
            begin
                // host events also need tracing on
                if (run_q && (it.from_offload || trace_q))
                begin
                    for (i = 0; i < shadow_used; i++)
                        if (hit < 0 && shadow_tbl[i].slot == it.key_slot
                            && shadow_tbl[i].endpoint == it.key_endpoint)
                            hit = i;
                    if (hit >= 0)
                    begin
                        // count saturates at the top
                        if (shadow_tbl[hit].count != COUNT_MAX)
                            shadow_tbl[hit].count++;
                        r.status = ST_COUNTED;
                    end
                    else if (shadow_used >= TABLE_ENTRIES)
                        r.status = ST_FULL;
                    else
                    begin
                        hit = shadow_used;
                        shadow_tbl[hit].slot = it.key_slot;
                        shadow_tbl[hit].endpoint = it.key_endpoint;
                        shadow_tbl[hit].direction = it.direction_in;
                        shadow_tbl[hit].cls = it.from_offload ? CLASS_AUDIO : it.class_code;
                        shadow_tbl[hit].count = 32'd1;
                        shadow_used++;
                        r.status = ST_CREATED;
                    end
                end
            end
            MODE_CLEAR:
            begin
                // no clearing while running
                if (run_q)
                    r.status = ST_REFUSED;
                else
                begin
                    for (i = 0; i < TABLE_ENTRIES; i++)
                        shadow_tbl[i] = '0;
                    shadow_used = 0;
                    r.status = ST_CLEARED;
                end
            end
            MODE_READ:
            begin
                if (it.read_index < shadow_used)
                begin
                    hit = it.read_index;
                    r.status = ST_READ_OK;
                end
                else
                    r.status = ST_BAD_INDEX;
            end
            default:
            begin
                // spare mode: nothing happens
            end
        endcase
        r.entries_in_use = shadow_used[2:0];
        // entry fields stay zero unless an entry was touched
        if (hit >= 0)
        begin
            r.entry_index = hit[2:0];
            r.entry_slot = shadow_tbl[hit].slot;
            r.entry_endpoint = shadow_tbl[hit].endpoint;
            r.entry_direction = shadow_tbl[hit].direction;
            r.entry_class = shadow_tbl[hit].cls;
            r.entry_count = shadow_tbl[hit].count;
        end
        return r;
    endfunction

    function automatic in_item_t req(logic [1:0] mode, logic [7:0] slot, logic [7:0] ep,
                                     logic dir, logic [7:0] cls, logic off, logic [2:0] ridx);
        in_item_t it;
        it.mode = mode;
        it.key_slot = slot;
        it.key_endpoint = ep;
        it.direction_in = dir;
        it.class_code = cls;
        it.from_offload = off;
        it.read_index = ridx;
        return it;
    endfunction

    function automatic out_item_t rsp(logic [2:0] st, logic [2:0] used, logic [2:0] idx,
                                      logic [7:0] slot, logic [7:0] ep, logic dir,
                                      logic [7:0] cls, logic [31:0] cnt);
        out_item_t r;
        r.status = st;
        r.entries_in_use = used;
        r.entry_index = idx;
        r.entry_slot = slot;
        r.entry_endpoint = ep;
        r.entry_direction = dir;
        r.entry_class = cls;
        r.entry_count = cnt;
        return r;
    endfunction

    // result that carries no entry
    function automatic out_item_t bare(logic [2:0] st, logic [2:0] used);
        return rsp(st, used, 3'd0, 8'd0, 8'd0, 1'b0, 8'd0, 32'd0);
    endfunction

    function automatic row_t item_row(in_item_t it, bit typed = 1'b0, out_item_t res = '0);
        row_t r;
        r.is_reg = 1'b0;
        r.reg_idx = 1'b0;
        r.reg_val = 1'b0;
        r.item = it;
        r.typed = typed;
        r.typed_res = res;
        return r;
    endfunction

    function automatic row_t reg_row(logic idx, logic val);
        row_t r;
        r = item_row('0);
        r.is_reg = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    // random item aimed mostly at the current key pool
    function automatic in_item_t random_request();
        logic [31:0] raw;
        in_item_t it;
        int pick;
        int k;
        raw = $urandom;
        it = raw[$bits(in_item_t)-1:0];
        pick = $urandom_range(0, 99);
        if (pick < 60)
            it.mode = MODE_EVENT;
        else if (pick < 85)
            it.mode = MODE_READ;
        else if (pick < 95)
            it.mode = MODE_CLEAR;
        else
            it.mode = MODE_UNUSED;
        if ($urandom_range(0, 9) != 0)
        begin
            k = $urandom_range(0, KEY_POOL - 1);
            it.key_slot = pool_slot[k];
            it.key_endpoint = pool_ep[k];
        end
        return it;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    // register write; with more set the channel stays valid for the next one
    task automatic write_reg(logic idx, logic val, bit more = 1'b0);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        if (idx == CFG_RUNNING)
            run_q = val;
        else
            trace_q = val;
        if (!more)
            cfg_valid <= 1'b0;
    endtask

    // every item taken and every result back
    task automatic wait_drained();
        while (accepted_cnt != pushed_cnt || expected_results.size() != 0)
            @(posedge clk);
    endtask

    // sender: offers queued items, holds them while stalled, idles in bursts
    initial
    begin : feed_items
        row_t cur;
        out_item_t pred;
        int gap_left;
        gap_left = 0;
        cur = item_row('0);
        forever
        begin
            @(posedge clk);
            if (in_valid && !in_stall)
            begin
                pred = predict_table_result(cur.item);
                expected_results.push_back(cur.typed ? cur.typed_res : pred);
                accepted_cnt++;
                if (pred.status != ST_IGNORED)
                    useful_cnt++;
            end
            if (in_valid && in_stall)
            begin
                // stalled item stays put
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (!quiet && send_q.size() != 0 && $urandom_range(0, 99) < idle_pct)
            begin
                gap_left = $urandom_range(1, 15) - 1;
                in_valid <= 1'b0;
            end
            else if (send_q.size() != 0)
            begin
                cur = send_q.pop_front();
                in_item <= cur.item;
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver: checks each result against the oldest expectation, stalls at random
    initial
    begin : drain_results
        out_item_t want;
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left = 0;
        for (int s = 0; s < 8; s++)
            status_tally[s] = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with no item pending, status %0d", out_item.status);
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    checked_cnt++;
                    status_tally[want.status]++;
                    check_field("status", 32'(want.status), 32'(out_item.status));
                    check_field("entries_in_use", 32'(want.entries_in_use),
                                32'(out_item.entries_in_use));
                    check_field("entry_index", 32'(want.entry_index),
                                32'(out_item.entry_index));
                    check_field("entry_slot", 32'(want.entry_slot), 32'(out_item.entry_slot));
                    check_field("entry_endpoint", 32'(want.entry_endpoint),
                                32'(out_item.entry_endpoint));
                    check_field("entry_direction", 32'(want.entry_direction),
                                32'(out_item.entry_direction));
                    check_field("entry_class", 32'(want.entry_class),
                                32'(out_item.entry_class));
                    check_field("entry_count", want.entry_count, out_item.entry_count);
                end
            end
            // long hold-off lets the block back up into its input
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 99) < idle_pct)
            begin
                stall_left = $urandom_range(1, 15) - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin : run_test
        int phase;
        logic run_v;
        logic trace_v;

        for (int i = 0; i < TABLE_ENTRIES; i++)
            shadow_tbl[i] = '0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part: stopped, running without trace, full table, reads past the end
        directed = '{
            item_row(req(MODE_READ, 0, 0, 0, 0, 0, 0), 1, bare(ST_BAD_INDEX, 0)),
            item_row(req(MODE_EVENT, 3, 8'h81, 1, 3, 0, 0), 1, bare(ST_IGNORED, 0)),
            item_row(req(MODE_CLEAR, 0, 0, 0, 0, 0, 0), 1, bare(ST_CLEARED, 0)),
            item_row(req(MODE_UNUSED, 8'hFF, 8'hFF, 1, 8'hFF, 1, 7), 1,
                     bare(ST_IGNORED, 0)),
            reg_row(CFG_RUNNING, 1'b1),
            // host event without tracing
            item_row(req(MODE_EVENT, 3, 8'h81, 1, 3, 0, 0), 1, bare(ST_IGNORED, 0)),
            // offload events get the audio class whatever class_code says
            item_row(req(MODE_EVENT, 0, 0, 1, 8'hFF, 1, 0), 1,
                     rsp(ST_CREATED, 1, 0, 0, 0, 1, CLASS_AUDIO, 1)),
            item_row(req(MODE_EVENT, 0, 0, 1, 8'hFF, 1, 0), 1,
                     rsp(ST_COUNTED, 1, 0, 0, 0, 1, CLASS_AUDIO, 2)),
            item_row(req(MODE_CLEAR, 0, 0, 0, 0, 0, 0), 1, bare(ST_REFUSED, 1)),
            reg_row(CFG_HOST_TRACE, 1'b1),
            item_row(req(MODE_EVENT, 8'hFF, 8'hFF, 0, 8'hFF, 0, 0), 1,
                     rsp(ST_CREATED, 2, 1, 8'hFF, 8'hFF, 0, 8'hFF, 1)),
            item_row(req(MODE_EVENT, 8'hFF, 8'h00, 1, 8'h80, 0, 0)),
            item_row(req(MODE_EVENT, 8'h00, 8'hFF, 0, 8'h7F, 0, 0)),
            item_row(req(MODE_EVENT, 8'hAA, 8'h55, 1, 8'h00, 1, 0)),
            // table full, new key is dropped
            item_row(req(MODE_EVENT, 8'h55, 8'hAA, 0, 8'h01, 0, 0), 1, bare(ST_FULL, 5)),
            item_row(req(MODE_EVENT, 8'hFF, 8'hFF, 0, 8'hFF, 0, 0)),
            item_row(req(MODE_READ, 0, 0, 0, 0, 0, 0)),
            item_row(req(MODE_READ, 0, 0, 0, 0, 0, 1)),
            item_row(req(MODE_READ, 0, 0, 0, 0, 0, 2)),
            item_row(req(MODE_READ, 0, 0, 0, 0, 0, 3)),
            item_row(req(MODE_READ, 0, 0, 0, 0, 0, 4)),
            item_row(req(MODE_READ, 0, 0, 0, 0, 0, 5), 1, bare(ST_BAD_INDEX, 5)),
            item_row(req(MODE_READ, 0, 0, 0, 0, 0, 6), 1, bare(ST_BAD_INDEX, 5)),
            item_row(req(MODE_READ, 8'hFF, 8'hFF, 1, 8'hFF, 1, 7), 1,
                     bare(ST_BAD_INDEX, 5)),
            item_row(req(MODE_UNUSED, 0, 0, 0, 0, 0, 0), 1, bare(ST_IGNORED, 5)),
            reg_row(CFG_RUNNING, 1'b0),
            item_row(req(MODE_EVENT, 8'h12, 8'h34, 1, 8'h56, 1, 0), 1,
                     bare(ST_IGNORED, 5)),
            item_row(req(MODE_CLEAR, 0, 0, 0, 0, 0, 0), 1, bare(ST_CLEARED, 0)),
            item_row(req(MODE_READ, 0, 0, 0, 0, 0, 0), 1, bare(ST_BAD_INDEX, 0))
        };

        foreach (directed[n])
        begin
            if (directed[n].is_reg)
            begin
                wait_drained();
                write_reg(directed[n].reg_idx, directed[n].reg_val);
            end
            else
            begin
                send_q.push_back(directed[n]);
                pushed_cnt++;
            end
        end

        // random phases, each with fresh settings and a fresh key pool
        phase = 0;
        while (pushed_cnt < ITEM_GOAL)
        begin
            wait_drained();
            // last stretch runs flat out
            if (pushed_cnt > ITEM_GOAL * 85 / 100)
                quiet = 1'b1;
            idle_pct = (phase % 3 == 1) ? 0 : 30;
            if (phase < 2)
            begin
                run_v = 1'b1;
                trace_v = 1'b1;
            end
            else
            begin
                // stopped now and then so clears go through and the table refills
                run_v = ($urandom_range(0, 2) != 0);
                trace_v = 1'($urandom_range(0, 1));
            end
            write_reg(CFG_RUNNING, run_v, 1'b1);
            write_reg(CFG_HOST_TRACE, trace_v);
            for (int k = 0; k < KEY_POOL; k++)
            begin
                pool_slot[k] = 8'($urandom_range(0, 255));
                pool_ep[k] = 8'($urandom_range(0, 255));
            end
            if (phase == 1)
                long_hold_req = 1'b1;
            for (int j = 0; j < PHASE_ITEMS; j++)
            begin
                send_q.push_back(item_row(random_request()));
                pushed_cnt++;
            end
            phase++;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d items (%0d not ignored) over %0d random phases, %0d checked",
                 accepted_cnt, useful_cnt, phase, checked_cnt);
        $display("created %0d counted %0d full %0d cleared %0d refused %0d bad index %0d",
                 status_tally[ST_CREATED], status_tally[ST_COUNTED], status_tally[ST_FULL],
                 status_tally[ST_CLEARED], status_tally[ST_REFUSED],
                 status_tally[ST_BAD_INDEX]);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
